FILE: src/weighted_point_residual_macros.svh
`ifndef WEIGHTED_POINT_RESIDUAL_MACROS_SVH
`define WEIGHTED_POINT_RESIDUAL_MACROS_SVH

// Check a condition in the same cycle as its trigger
`define WPR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("weighted_point_residual: same-cycle check failed");

// Check a condition in the cycle after its trigger
`define WPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("weighted_point_residual: next-cycle check failed");

`endif

FILE: src/wpr_pkg.sv
package wpr_pkg;

  // Coordinate and register geometry
  localparam int COORD_W       = 16;
  localparam int ROT_FRAC_DEF  = 14;
  localparam int REG_W         = 3 * COORD_W;
  localparam int RES_W         = 32;
  localparam int RES_SUM_W     = RES_W + 2;
  localparam int N_IN_FIELDS   = 12;
  localparam int IN_TDATA_W    = ((N_IN_FIELDS * COORD_W + 7) / 8) * 8;
  localparam int OUT_BITS      = 3 * RES_W + RES_SUM_W;
  localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_BITS;
  localparam int CFG_ADDR_W    = 2;

  // Register reset values: identity rotation (row 0 slightly under one), zero shift
  localparam logic [REG_W-1:0] ROT_ROW0_RST = 48'h3FFF_0000_0000;
  localparam logic [REG_W-1:0] ROT_ROW1_RST = 48'h0000_4000_0000;
  localparam logic [REG_W-1:0] ROT_ROW2_RST = 48'h0000_0000_4000;
  localparam logic [REG_W-1:0] TRANS_RST    = '0;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ROT_ROW0 = 2'd0,
    CFG_ROT_ROW1 = 2'd1,
    CFG_ROT_ROW2 = 2'd2,
    CFG_TRANS    = 2'd3
  } cfg_idx_t;

  // Load enables for the two register stages of a dot product unit
  typedef struct packed {
    logic ld_prod;
    logic ld_sum;
  } dot_en_t;

endpackage

FILE: src/weighted_point_residual.sv
// Throughput: one point pair per cycle; each stage holds while the one after it is full
// and stalled, so bubbles still fill while a result waits on out_tready.
// Reset (rst_n, synchronous, active low) empties the pipeline and loads the
// identity rotation and zero translation into the configuration registers.
`include "weighted_point_residual_macros.svh"

module weighted_point_residual #(
  parameter int ROT_FRAC_BITS = wpr_pkg::ROT_FRAC_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // sens_x, sens_y, sens_z, model_x, model_y, model_z, wt_a .. wt_f (16 bits each)
  input  logic [wpr_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // resid_x[31:0], resid_y[63:32], resid_z[95:64], resid_sum[129:96], zero pad
  output logic [wpr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_wr_en,
  input  logic [wpr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [wpr_pkg::REG_W-1:0]         cfg_wdata
);
  import wpr_pkg::*;

  localparam int CW    = COORD_W;
  localparam int NST   = 7;
  localparam int RSUM_W = 2 * CW + 2;
  localparam int RND_W = RSUM_W + 1;
  localparam int RM_W  = RND_W - ROT_FRAC_BITS;
  localparam int ST_W  = CW + 1;
  localparam int DW    = ((ST_W > RM_W) ? ST_W : RM_W) + 1;
  localparam int BSUM_W = CW + DW + 2;
  localparam logic signed [RND_W-1:0] HALF_LSB =
    {{(RND_W-1){1'b0}}, 1'b1} << (ROT_FRAC_BITS - 1);

  // Configuration registers
  logic [REG_W-1:0] rot_row_r [3];
  logic [REG_W-1:0] trans_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_row_r[0] <= ROT_ROW0_RST;
      rot_row_r[1] <= ROT_ROW1_RST;
      rot_row_r[2] <= ROT_ROW2_RST;
      trans_r      <= TRANS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_ROT_ROW0: rot_row_r[0] <= cfg_wdata;
        CFG_ROT_ROW1: rot_row_r[1] <= cfg_wdata;
        CFG_ROT_ROW2: rot_row_r[2] <= cfg_wdata;
        CFG_TRANS:    trans_r      <= cfg_wdata;
      endcase
    end
  end

  // Unpack register entries (x/col0 in the top field) and input fields
  logic signed [CW-1:0] rot_e [3][3];
  logic signed [CW-1:0] trans_e [3];
  logic signed [CW-1:0] sens [3];
  logic signed [CW-1:0] model [3];
  logic signed [CW-1:0] wt [6];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rot_e[i][j] = rot_row_r[i][(2-j)*CW +: CW];
      end
      trans_e[i] = trans_r[(2-i)*CW +: CW];
      sens[i]    = in_tdata[i*CW +: CW];
      model[i]   = in_tdata[(3+i)*CW +: CW];
    end
    for (int k = 0; k < 6; k++) begin
      wt[k] = in_tdata[(6+k)*CW +: CW];
    end
  end

  // Valid bits and per-stage ready
  logic [NST:1] v_r;
  logic [NST:1] v_nxt;
  logic [NST:1] rdy;

  always_comb begin
    rdy[NST] = !v_r[NST] || out_tready;
    for (int k = NST - 1; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_nxt = v_r;
    if (rdy[1]) begin
      v_nxt[1] = in_tvalid;
    end
    for (int k = 2; k <= NST; k++) begin
      if (rdy[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = rdy[1];
  assign out_tvalid = v_r[NST];

  // Stages 1-2: rotated model point R*m (products, then row sums)
  logic signed [RSUM_W-1:0] rsum [3];
  dot_en_t rot_en;
  assign rot_en = '{ld_prod: rdy[1], ld_sum: rdy[2]};

  for (genvar gi = 0; gi < 3; gi++) begin : g_rot
    wpr_dot3 #(.A_W(CW), .B_W(CW)) u_rot (
      .clk (clk),
      .en  (rot_en),
      .a   (rot_e[gi]),
      .b   (model),
      .sum (rsum[gi])
    );
  end

  // Carry s - t and the weights alongside
  logic signed [ST_W-1:0] st_s1_r [3];
  logic signed [ST_W-1:0] st_s2_r [3];
  logic signed [CW-1:0]   wt_s1_r [6];
  logic signed [CW-1:0]   wt_s2_r [6];
  logic signed [CW-1:0]   wt_s3_r [6];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int i = 0; i < 3; i++) begin
        st_s1_r[i] <= ST_W'(sens[i]) - ST_W'(trans_e[i]);
      end
      wt_s1_r <= wt;
    end
    if (rdy[2]) begin
      st_s2_r <= st_s1_r;
      wt_s2_r <= wt_s1_r;
    end
    if (rdy[3]) begin
      wt_s3_r <= wt_s2_r;
    end
  end

  // Stage 3: round R*m half up to Q12.8 and form d = (s - t) - R*m
  logic signed [RND_W-1:0] rnd [3];
  logic signed [RM_W-1:0]  rm [3];
  logic signed [DW-1:0]    d_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = RND_W'(rsum[i]) + HALF_LSB;
      rm[i]  = rnd[i][RND_W-1:ROT_FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i] <= DW'(st_s2_r[i]) - DW'(rm[i]);
      end
    end
  end

  // Stages 4-5: weighted residual B*d with symmetric B
  logic signed [CW-1:0]     brow [3][3];
  logic signed [BSUM_W-1:0] bsum [3];
  dot_en_t wt_en;
  assign wt_en = '{ld_prod: rdy[4], ld_sum: rdy[5]};

  always_comb begin
    brow[0] = '{wt_s3_r[0], wt_s3_r[1], wt_s3_r[2]};
    brow[1] = '{wt_s3_r[1], wt_s3_r[3], wt_s3_r[4]};
    brow[2] = '{wt_s3_r[2], wt_s3_r[4], wt_s3_r[5]};
  end

  for (genvar gi = 0; gi < 3; gi++) begin : g_wt
    wpr_dot3 #(.A_W(CW), .B_W(DW)) u_wt (
      .clk (clk),
      .en  (wt_en),
      .a   (brow[gi]),
      .b   (d_r),
      .sum (bsum[gi])
    );
  end

  // Stage 6: absolute value, saturate to 32 bits
  logic [BSUM_W-1:0] mag [3];
  logic [RES_W-1:0]  res_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = bsum[i][BSUM_W-1] ? BSUM_W'(-bsum[i]) : BSUM_W'(bsum[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      for (int i = 0; i < 3; i++) begin
        res_r[i] <= (|mag[i][BSUM_W-1:RES_W]) ? {RES_W{1'b1}} : mag[i][RES_W-1:0];
      end
    end
  end

  // Stage 7: output register with the residual sum
  logic [RES_W-1:0]     res_o_r [3];
  logic [RES_SUM_W-1:0] res_sum_r;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      res_o_r   <= res_r;
      res_sum_r <= RES_SUM_W'(res_r[0]) + RES_SUM_W'(res_r[1]) + RES_SUM_W'(res_r[2]);
    end
  end

  assign out_tdata = {{OUT_PAD_W{1'b0}}, res_sum_r, res_o_r[2], res_o_r[1], res_o_r[0]};

  // Checks
  `WPR_ASSERT_NEXT(a_accept_fills_s1, in_tvalid && in_tready, v_r[1])
  `WPR_ASSERT_SAME(a_full_stall_blocks, (&v_r) && !out_tready, !in_tready)
  `WPR_ASSERT_SAME(a_sum_matches, out_tvalid,
    res_sum_r == RES_SUM_W'(res_o_r[0]) + RES_SUM_W'(res_o_r[1]) + RES_SUM_W'(res_o_r[2]))

endmodule

FILE: src/wpr_dot3.sv
module wpr_dot3 #(
  parameter int A_W = 16,
  parameter int B_W = 16
) (
  input  logic                     clk,
  input  wpr_pkg::dot_en_t         en,
  input  logic signed [A_W-1:0]    a [3],
  input  logic signed [B_W-1:0]    b [3],
  output logic signed [A_W+B_W+1:0] sum
);
  import wpr_pkg::*;

  localparam int P_W = A_W + B_W;
  localparam int S_W = P_W + 2;

  logic signed [P_W-1:0] prod_r [3];
  logic signed [S_W-1:0] sum_r;
  logic signed [S_W-1:0] sum_nxt;

  // Stage one: three products
  always_ff @(posedge clk) begin
    if (en.ld_prod) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= a[i] * b[i];
      end
    end
  end

  // Stage two: add the products at full width
  always_comb begin
    sum_nxt = S_W'(prod_r[0]) + S_W'(prod_r[1]) + S_W'(prod_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en.ld_sum) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule
